@@ design/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types, register indexes and a helper function for the pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgTempCalib  = 2'd0;
  localparam logic [1:0] CfgPressCalibA = 2'd1;
  localparam logic [1:0] CfgPressCalibB = 2'd2;
  localparam logic [1:0] CfgPressCalibC = 2'd3;

  // Fixed constants of the compensation polynomials.
  localparam logic [33:0] OffsetFine = 34'd128000;
  localparam logic [20:0] PressBase  = 21'd1048576;
  localparam logic [63:0] PressScale = 64'd3125;
  localparam int unsigned DivBits    = 64;

  // Temperature results that travel alongside the pressure work.
  typedef struct packed {
    logic [31:0] centi;
    logic [31:0] fine;
  } bsc_temp_t;

  // Sign-extend a 16-bit calibration word to 64 bits.
  function automatic logic [63:0] sx16to64(input logic [15:0] v);
    sx16to64 = {{48{v[15]}}, v};
  endfunction

endpackage

@@ design/bsc_temp.sv @@
// ----------------------------------------------------------------------------
// Temperature stages
// Four pipeline stages computing fine temperature, centi-degrees and the
// first pressure variable, all temperature math wrapping at 32 bits.
// ----------------------------------------------------------------------------
module bsc_temp
  import bsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [19:0]        raw_t_i,
  input  logic [19:0]        raw_p_i,
  input  logic [47:0]        temp_calib_i,
  output logic               vld_o,
  output bsc_temp_t          temp_o,
  output logic signed [33:0] v1_o,
  output logic [20:0]        p0_o
);

  logic [31:0] t1, t2, t3;
  logic [31:0] a0, b0;
  logic [3:0]  vld_q;
  logic [31:0] a1_q, bb_q, a2_q, bq_q, fine_q, centi_q;
  logic [31:0] fine_out_q;
  logic [31:0] fine_mul;
  logic [19:0] rp1_q, rp2_q, rp3_q;
  logic signed [33:0] v1_q;
  logic [20:0] p0_q;

  assign t1 = {16'b0, temp_calib_i[15:0]};
  assign t2 = {{16{temp_calib_i[31]}}, temp_calib_i[31:16]};
  assign t3 = {{16{temp_calib_i[47]}}, temp_calib_i[47:32]};

  // Differences against T1 feed the two temperature terms.
  assign a0 = {15'b0, raw_t_i[19:3]} - (t1 << 1);
  assign b0 = {16'b0, raw_t_i[19:4]} - t1;
  assign fine_mul = fine_q * 32'd5 + 32'd128;

  // Valid bits advance with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  // Stage datapath.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= a0 * t2;
      bb_q    <= b0 * b0;
      rp1_q   <= raw_p_i;
      a2_q    <= 32'($signed(a1_q) >>> 11);
      bq_q    <= 32'($signed(bb_q) >>> 12) * t3;
      rp2_q   <= rp1_q;
      fine_q  <= a2_q + 32'($signed(bq_q) >>> 14);
      rp3_q   <= rp2_q;
      centi_q <= 32'($signed(fine_mul) >>> 8);
      v1_q    <= $signed({{2{fine_q[31]}}, fine_q} - OffsetFine);
      p0_q    <= PressBase - {1'b0, rp3_q};
      fine_out_q <= fine_q;
    end
  end

  assign vld_o  = vld_q[3];
  assign temp_o = '{centi: centi_q, fine: fine_out_q};
  assign v1_o   = v1_q;
  assign p0_o   = p0_q;

endmodule

@@ design/bsc_pcoef.sv @@
// ----------------------------------------------------------------------------
// Pressure coefficient stages
// Five stages forming the 64-bit dividend and divisor of the pressure
// division, with every product and sum wrapping at 64 bits.
// ----------------------------------------------------------------------------
module bsc_pcoef
  import bsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  bsc_temp_t          temp_i,
  input  logic signed [33:0] v1_i,
  input  logic [20:0]        p0_i,
  input  logic [63:0]        calib_a_i,
  input  logic [63:0]        calib_b_i,
  output logic               vld_o,
  output bsc_temp_t          temp_o,
  output logic [63:0]        num_o,
  output logic [63:0]        den_o
);

  logic [4:0]  vld_q;
  bsc_temp_t   tmp_q [5];
  logic [20:0] p0_q [3];
  logic signed [67:0] sq_full;
  logic signed [49:0] m5_full, m2_full;
  logic [63:0] sq_q, m5_q, m2_q;
  logic [63:0] v2a_q, t3p_q, v2b_q, x2_q;
  logic [63:0] v2_q, u_q, w_q, num0_q, num_q, den_q;

  assign sq_full = v1_i * v1_i;
  assign m5_full = v1_i * $signed(calib_b_i[15:0]);
  assign m2_full = v1_i * $signed(calib_a_i[31:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  // Polynomial stages; each product is registered before the next.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tmp_q[0] <= temp_i;
      for (int i = 1; i < 5; i++) begin
        tmp_q[i] <= tmp_q[i-1];
      end
      p0_q[0] <= p0_i;
      for (int i = 1; i < 3; i++) begin
        p0_q[i] <= p0_q[i-1];
      end
      sq_q   <= sq_full[63:0];
      m5_q   <= {{14{m5_full[49]}}, m5_full};
      m2_q   <= {{14{m2_full[49]}}, m2_full};
      v2a_q  <= sq_q * sx16to64(calib_b_i[31:16]);
      t3p_q  <= sq_q * sx16to64(calib_a_i[47:32]);
      v2b_q  <= (m5_q << 17) + (sx16to64(calib_a_i[63:48]) << 35);
      x2_q   <= m2_q << 12;
      v2_q   <= v2a_q + v2b_q;
      u_q    <= 64'($signed(t3p_q) >>> 8) + x2_q;
      w_q    <= (64'h0000_8000_0000_0000 + u_q) * {48'b0, calib_a_i[15:0]};
      num0_q <= ({43'b0, p0_q[2]} << 31) - v2_q;
      den_q  <= 64'($signed(w_q) >>> 33);
      num_q  <= num0_q * PressScale;
    end
  end

  assign vld_o  = vld_q[4];
  assign temp_o = tmp_q[4];
  assign num_o  = num_q;
  assign den_o  = den_q;

endmodule

@@ design/bsc_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division, one quotient bit per stage, with a sign stage in
// front and a sign fix stage behind; truncates toward zero.
// ----------------------------------------------------------------------------
module bsc_div
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  bsc_temp_t   temp_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        vld_o,
  output bsc_temp_t   temp_o,
  output logic        ok_o,
  output logic [63:0] quo_o
);

  logic [DivBits:0] vld_q;
  bsc_temp_t        tmp_q [DivBits+1];
  logic [63:0]      rem_q [DivBits+1];
  logic [63:0]      nn_q  [DivBits+1];
  logic [63:0]      dd_q  [DivBits+1];
  logic [63:0]      qq_q  [DivBits+1];
  logic             neg_q [DivBits+1];
  logic             ok_q  [DivBits+1];
  logic             vld_out_q;
  bsc_temp_t        tmp_out_q;
  logic             ok_out_q;
  logic [63:0]      quo_q;

  // Valid bits of the sign stage, the bit stages and the fix stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[DivBits-1:0], vld_i};
      vld_out_q <= vld_q[DivBits];
    end
  end

  // Operands are taken to magnitudes; a zero divisor marks the item.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tmp_q[0] <= temp_i;
      rem_q[0] <= '0;
      nn_q[0]  <= num_i[63] ? 64'd0 - num_i : num_i;
      dd_q[0]  <= den_i[63] ? 64'd0 - den_i : den_i;
      qq_q[0]  <= '0;
      neg_q[0] <= num_i[63] ^ den_i[63];
      ok_q[0]  <= (den_i != '0);
    end
  end

  // One quotient bit per stage.
  for (genvar g = 0; g < DivBits; g++) begin : g_bit
    logic [63:0] trial;
    logic        ge;
    assign trial = {rem_q[g][62:0], nn_q[g][63]};
    assign ge    = (trial >= dd_q[g]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tmp_q[g+1] <= tmp_q[g];
        rem_q[g+1] <= ge ? trial - dd_q[g] : trial;
        nn_q[g+1]  <= nn_q[g] << 1;
        dd_q[g+1]  <= dd_q[g];
        qq_q[g+1]  <= {qq_q[g][62:0], ge};
        neg_q[g+1] <= neg_q[g];
        ok_q[g+1]  <= ok_q[g];
      end
    end
  end

  // Sign fix of the quotient.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tmp_out_q <= tmp_q[DivBits];
      ok_out_q  <= ok_q[DivBits];
      quo_q     <= neg_q[DivBits] ? 64'd0 - qq_q[DivBits] : qq_q[DivBits];
    end
  end

  assign vld_o  = vld_out_q;
  assign temp_o = tmp_out_q;
  assign ok_o   = ok_out_q;
  assign quo_o  = quo_q;

endmodule

@@ design/bsc_pfin.sv @@
// ----------------------------------------------------------------------------
// Pressure finishing stages
// Five stages applying the P7 to P9 corrections, saturating the result
// and holding the output register of the block.
// ----------------------------------------------------------------------------
module bsc_pfin
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  bsc_temp_t   temp_i,
  input  logic        ok_i,
  input  logic [63:0] quo_i,
  input  logic [63:0] calib_b_i,
  input  logic [15:0] calib_c_i,
  output logic        vld_o,
  output bsc_temp_t   temp_o,
  output logic [31:0] press_o,
  output logic        press_ok_o
);

  logic [4:0]  vld_q;
  bsc_temp_t   tmp_q [5];
  logic        ok_q [5];
  logic [63:0] p_q [3];
  logic [63:0] h;
  logic [63:0] hl_q;
  logic [31:0] hm_q;
  logic [63:0] c2m_q, hh_q, c2_q, c1m_q, c2b_q, s_q;
  logic [63:0] fin;
  logic [31:0] sat;
  logic [31:0] press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  // The square of the shifted quotient is built from two 32-bit products.
  assign h = 64'($signed(quo_i) >>> 13);

  // Final value and saturation to 32 unsigned bits.
  assign fin = 64'($signed(s_q) >>> 8) + (sx16to64(calib_b_i[47:32]) << 4);
  always_comb begin
    if (fin[63]) begin
      sat = '0;
    end else if (fin[62:32] != '0) begin
      sat = '1;
    end else begin
      sat = fin[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tmp_q[0] <= temp_i;
      ok_q[0]  <= ok_i;
      for (int i = 1; i < 5; i++) begin
        tmp_q[i] <= tmp_q[i-1];
        ok_q[i]  <= ok_q[i-1];
      end
      p_q[0]  <= quo_i;
      p_q[1]  <= p_q[0];
      p_q[2]  <= p_q[1];
      hl_q    <= 64'(h[31:0]) * 64'(h[31:0]);
      hm_q    <= h[63:32] * h[31:0];
      c2m_q   <= quo_i * sx16to64(calib_b_i[63:48]);
      hh_q    <= hl_q + {hm_q[30:0], 33'b0};
      c2_q    <= 64'($signed(c2m_q) >>> 19);
      c1m_q   <= hh_q * sx16to64(calib_c_i);
      c2b_q   <= c2_q;
      s_q     <= p_q[2] + 64'($signed(c1m_q) >>> 25) + c2b_q;
      press_q <= ok_q[3] ? sat : '0;
    end
  end

  assign vld_o      = vld_q[4];
  assign temp_o     = tmp_q[4];
  assign press_o    = press_q;
  assign press_ok_o = ok_q[4];

endmodule

@@ design/barometric_sensor_compensation_top.sv @@
// ----------------------------------------------------------------------------
// Barometric sensor compensation top level
// Integer calibration of raw temperature and pressure readings.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one raw temperature and one raw pressure reading
// per transfer; the output channel returns temperature in 0.01 degree units,
// the fine temperature, pressure in Q24.8 pascals and a pressure valid flag.
// Calibration words are to be written through the write port only while no
// reading is in flight, which the block does not enforce; they are read by
// the temperature, coefficient and finishing stages. The pipeline has 4
// temperature stages, 5 pressure coefficient stages, 66 divider stages (one
// quotient bit per stage) and 5 finishing stages. Throughput is one reading
// per cycle while no result is stalled, set by the one-bit-per-stage divider.
// Reset clears all valid bits and calibration registers to zero.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_top
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] temperature_centi_o,
  output logic signed [31:0] fine_temperature_o,
  output logic [31:0] pressure_q24_8_o,
  output logic        pressure_valid_o
);

  logic [47:0] temp_calib_q;
  logic [63:0] press_calib_a_q, press_calib_b_q;
  logic [15:0] press_calib_c_q;
  logic        en;

  logic               t_vld, c_vld, d_vld, f_vld, d_ok;
  bsc_temp_t          t_tmp, c_tmp, d_tmp, f_tmp;
  logic signed [33:0] t_v1;
  logic [20:0]        t_p0;
  logic [63:0]        c_num, c_den, d_quo;

  // Calibration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q    <= '0;
      press_calib_a_q <= '0;
      press_calib_b_q <= '0;
      press_calib_c_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTempCalib:   temp_calib_q    <= cfg_wdata_i[47:0];
        CfgPressCalibA: press_calib_a_q <= cfg_wdata_i;
        CfgPressCalibB: press_calib_b_q <= cfg_wdata_i;
        CfgPressCalibC: press_calib_c_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is stalled.
  assign en         = !(f_vld && out_stall_i);
  assign in_stall_o = !en;

  bsc_temp u_temp (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i),
    .raw_t_i(raw_temperature_i), .raw_p_i(raw_pressure_i),
    .temp_calib_i(temp_calib_q),
    .vld_o(t_vld), .temp_o(t_tmp), .v1_o(t_v1), .p0_o(t_p0)
  );

  bsc_pcoef u_pcoef (
    .clk_i, .rst_ni, .en_i(en), .vld_i(t_vld), .temp_i(t_tmp),
    .v1_i(t_v1), .p0_i(t_p0),
    .calib_a_i(press_calib_a_q), .calib_b_i(press_calib_b_q),
    .vld_o(c_vld), .temp_o(c_tmp), .num_o(c_num), .den_o(c_den)
  );

  bsc_div u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(c_vld), .temp_i(c_tmp),
    .num_i(c_num), .den_i(c_den),
    .vld_o(d_vld), .temp_o(d_tmp), .ok_o(d_ok), .quo_o(d_quo)
  );

  bsc_pfin u_pfin (
    .clk_i, .rst_ni, .en_i(en), .vld_i(d_vld), .temp_i(d_tmp),
    .ok_i(d_ok), .quo_i(d_quo),
    .calib_b_i(press_calib_b_q), .calib_c_i(press_calib_c_q),
    .vld_o(f_vld), .temp_o(f_tmp), .press_o(pressure_q24_8_o),
    .press_ok_o(pressure_valid_o)
  );

  assign out_valid_o         = f_vld;
  assign temperature_centi_o = $signed(f_tmp.centi);
  assign fine_temperature_o  = $signed(f_tmp.fine);

endmodule

@@ design/bsc_checker.sv @@
// ----------------------------------------------------------------------------
// Compensation port checker
// Port-level assertions on the top level, attached with a bind statement.
// ----------------------------------------------------------------------------
module bsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pressure_q24_8_o,
  input logic        pressure_valid_o
);

  // A stalled result stays offered with the same pressure.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pressure_q24_8_o))
    else $error("stalled result changed");

  // A result without a valid pressure reports zero pressure.
  a_zero_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pressure_valid_o |-> pressure_q24_8_o == '0)
    else $error("pressure not zero for invalid divisor");

  // The input is only held back by a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A result that is taken frees the input in the same cycle.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |-> !in_stall_o)
    else $error("input stalled while result is taken");

endmodule

bind barometric_sensor_compensation_top bsc_checker u_bsc_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .pressure_q24_8_o, .pressure_valid_o
);

@@ dv/barometric_sensor_compensation_top_test.sv @@
// ----------------------------------------------------------------------------
// Barometric sensor compensation testbench
// Drives raw temperature and pressure readings under several calibration
// settings, with random idle bursts on both channels. Every result is
// compared with a predictor of the integer compensation polynomials.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_top_test;
  import bsc_pkg::*;

  // One expected compensation result.
  typedef struct {
    logic [31:0] centi;
    logic [31:0] fine;
    logic [31:0] press;
    logic        pvalid;
  } comp_result_t;

  // Calibration copy, compensation predictor and result checker.
  class comp_scoreboard;
    logic [47:0]   temp_cal;
    logic [63:0]   press_cal_a;
    logic [63:0]   press_cal_b;
    logic [15:0]   press_cal_c;
    comp_result_t  pending[$];
    int            mismatches;

    function void set_calib(logic [1:0] idx, logic [63:0] value);
      case (idx)
        CfgTempCalib:   temp_cal    = value[47:0];
        CfgPressCalibA: press_cal_a = value;
        CfgPressCalibB: press_cal_b = value;
        CfgPressCalibC: press_cal_c = value[15:0];
        default: ;
      endcase
    endfunction

    // Truncating signed division; the one overflowing quotient wraps.
    function logic signed [63:0] div_trunc(logic signed [63:0] n, logic signed [63:0] d);
      if (n == {1'b1, 63'd0} && d == -64'sd1) return n;
      return n / d;
    endfunction

    function comp_result_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
      logic signed [31:0] t1, t2, t3, ta, tb, fine_t;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] v1, v2, pr, h, c1, c2;
      comp_result_t r;
      t1 = {16'd0, temp_cal[15:0]};
      t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
      t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
      p1 = {48'd0, press_cal_a[15:0]};
      p2 = {{48{press_cal_a[31]}}, press_cal_a[31:16]};
      p3 = {{48{press_cal_a[47]}}, press_cal_a[47:32]};
      p4 = {{48{press_cal_a[63]}}, press_cal_a[63:48]};
      p5 = {{48{press_cal_b[15]}}, press_cal_b[15:0]};
      p6 = {{48{press_cal_b[31]}}, press_cal_b[31:16]};
      p7 = {{48{press_cal_b[47]}}, press_cal_b[47:32]};
      p8 = {{48{press_cal_b[63]}}, press_cal_b[63:48]};
      p9 = {{48{press_cal_c[15]}}, press_cal_c};
      // Temperature wraps at 32 bits.
      ta = {15'd0, raw_t[19:3]} - (t1 <<< 1);
      ta = (ta * t2) >>> 11;
      tb = {16'd0, raw_t[19:4]} - t1;
      tb = ((tb * tb) >>> 12) * t3;
      tb = tb >>> 14;
      fine_t = ta + tb;
      r.fine = fine_t;
      r.centi = (fine_t * 32'sd5 + 32'sd128) >>> 8;
      // Pressure wraps at 64 bits.
      v1 = {{32{fine_t[31]}}, fine_t} - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      r.press = '0;
      r.pvalid = 1'b0;
      if (v1 != 0) begin
        pr = 64'sd1048576 - {44'd0, raw_p};
        pr = div_trunc(((pr <<< 31) - v2) * 64'sd3125, v1);
        h = pr >>> 13;
        c1 = (p9 * h * h) >>> 25;
        c2 = (p8 * pr) >>> 19;
        pr = ((pr + c1 + c2) >>> 8) + (p7 <<< 4);
        if (pr < 0) r.press = '0;
        else if (pr > 64'sd4294967295) r.press = '1;
        else r.press = pr[31:0];
        r.pvalid = 1'b1;
      end
      return r;
    endfunction

    function void note_reading(logic [19:0] raw_t, logic [19:0] raw_p);
      pending.push_back(compensate(raw_t, raw_p));
    endfunction

    function void check_result(logic [31:0] centi, logic [31:0] fine,
                               logic [31:0] press, logic pvalid);
      comp_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: centi %0h", centi);
        return;
      end
      e = pending.pop_front();
      if (centi !== e.centi || fine !== e.fine || press !== e.press
          || pvalid !== e.pvalid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: exp centi %h fine %h press %h pv %b, got %h %h %h %b",
                   e.centi, e.fine, e.press, e.pvalid, centi, fine, press, pvalid);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgTempCalib;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [19:0] raw_temperature_i = '0;
  logic [19:0] raw_pressure_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] temperature_centi_o;
  logic signed [31:0] fine_temperature_o;
  logic [31:0] pressure_q24_8_o;
  logic        pressure_valid_o;

  comp_scoreboard sb = new();
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int unsigned cycles = 0;

  barometric_sensor_compensation_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: random stall bursts, and the result check.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(temperature_centi_o, fine_temperature_o,
                        pressure_q24_8_o, pressure_valid_o);
      if (stall_left > 0) stall_left <= stall_left - 1;
      else if (!quiet && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 15);
      out_stall_i <= (stall_left > 1) ||
                     (stall_left == 0 && !quiet && $urandom_range(0, 15) == 0);
    end
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("barometric_sensor_compensation_top test failed");
      $finish;
    end
  end

  // One register write; the write enable drops before the next call begins.
  task automatic write_calib(logic [1:0] idx, logic [63:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_calib(idx, value);
    @(posedge clk_i);
  endtask

  // Send one reading and wait for its transfer.
  task automatic send_reading(logic [19:0] raw_t, logic [19:0] raw_p);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_temperature_i <= raw_t;
    raw_pressure_i <= raw_p;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_reading(raw_t, raw_p);
  endtask

  // Let the pipeline empty before touching calibration.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [19:0] pick_raw(logic [19:0] typical);
    case ($urandom_range(0, 5))
      0: return 20'($urandom);
      1: return $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
      default: return typical + 20'($urandom_range(0, 131071)) - 20'd65536;
    endcase
  endfunction

  initial begin
    logic [63:0] cal[4];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All-zero calibration: the pressure divisor is zero.
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h7EED0, 20'h655AC);
    drain();

    // Typical calibration with field extremes.
    write_calib(CfgTempCalib, {16'hFC18, 16'd26435, 16'd27504});
    write_calib(CfgPressCalibA, {16'd2855, 16'd3024, 16'hD643, 16'd36477});
    write_calib(CfgPressCalibB, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
    write_calib(CfgPressCalibC, {48'hDEAD_BEEF_0123, 16'd6000});
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'h7EED0, 20'h655AC);
    send_reading(20'h80000, 20'h7FFFF);
    send_reading(20'h55555, 20'hAAAAA);
    send_reading(20'hAAAAA, 20'h55555);
    drain();

    // Extreme calibration words: all ones, then the most negative fields.
    for (int e = 0; e < 2; e++) begin
      for (int k = 0; k < 4; k++)
        write_calib(k[1:0], e == 0 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h8000_8000_8000_8000);
      send_reading(20'h00000, 20'h00000);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'h7EED0, 20'h655AC);
      drain();
    end

    // Random phases: typical calibration, with or without noise, or fully random words.
    for (int ph = 0; ph < 9; ph++) begin
      cal[0] = {16'hFC18, 16'd26435, 16'd27504};
      cal[1] = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
      cal[2] = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
      cal[3] = {$urandom, $urandom_range(0, 65535)} & 64'hFFFF_FFFF_FFFF_0000
               | 64'd6000;
      for (int k = 0; k < 4; k++) begin
        if (ph % 3 == 2) cal[k] = {$urandom, $urandom};
        else if (ph % 3 == 1) cal[k] = cal[k] ^ (64'h00FF_00FF_00FF_00FF &
                                                  {$urandom, $urandom});
        write_calib(k[1:0], cal[k]);
      end
      quiet = (ph == 8);
      for (int n = 0; n < 100; n++)
        send_reading(pick_raw(20'h7EED0), pick_raw(20'h655AC));
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("barometric_sensor_compensation_top test passed");
    else
      $display("barometric_sensor_compensation_top test failed");
    $finish;
  end

endmodule
